// ===== sv/gptw_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the guest page table walker
package gptw_pkg;

    localparam int unsigned AddrW = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_PAGING_ON  = 2'd0;
    localparam logic [1:0] CFG_PAE_ON     = 2'd1;
    localparam logic [1:0] CFG_TABLE_ROOT = 2'd2;

    // item kinds on the input channel
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_READ_RESP = 1'b1;

    // entry bits and address masks
    localparam int unsigned BitPresent = 0;
    localparam int unsigned BitPs      = 7;

    localparam logic [AddrW-1:0] NOT_MAPPED    = 32'hFFFF_FFFF;
    localparam logic [AddrW-1:0] ROOT_MASK     = 32'hFFFF_F000;
    localparam logic [AddrW-1:0] PAE_ROOT_MASK = 32'hFFFF_FFE0;
    localparam logic [AddrW-1:0] FRAME_4K_MASK = 32'hFFFF_F000;
    localparam logic [AddrW-1:0] FRAME_4M_MASK = 32'hFFC0_0000;
    localparam logic [AddrW-1:0] FRAME_2M_MASK = 32'hFFE0_0000;

    // walk position: idle or waiting for the entry of a table level
    typedef enum logic [1:0] {
        LVL_IDLE = 2'd0,
        LVL_1    = 2'd1,
        LVL_2    = 2'd2,
        LVL_3    = 2'd3
    } t_level;

    // decision for one accepted item
    typedef struct packed {
        logic             emit;
        logic             is_result;
        logic [AddrW-1:0] req_addr;
        logic [AddrW-1:0] phys_addr;
        logic             fault;
        t_level           next_level;
        logic [AddrW-1:0] next_vaddr;
    } t_walk_out;

endpackage

// ===== sv/gptw_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: input items, result items, configuration writes

interface gptw_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] virt_addr;
    logic [31:0] read_data;
    modport source (output valid, func, virt_addr, read_data, input ready);
    modport sink   (input valid, func, virt_addr, read_data, output ready);
endinterface

interface gptw_out_if;
    logic        valid;
    logic        ready;
    logic        is_result;
    logic [31:0] req_addr;
    logic [31:0] phys_addr;
    logic        fault;
    modport source (output valid, is_result, req_addr, phys_addr, fault, input ready);
    modport sink   (input valid, is_result, req_addr, phys_addr, fault, output ready);
endinterface

interface gptw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/guest_page_table_walker_core.sv =====
`timescale 1ns / 1ps
// top level of the guest page table walker
//
// channel     dir  handshake      payload
// i_req_ch    in   valid/ready    func, virt_addr, read_data
// o_rsp_ch    out  valid/ready    is_result, req_addr, phys_addr, fault
// i_cfg_ch    in   valid/ready    index (2b), data (32b); always ready
//
// one item per cycle while the output is not stalled: an item is decoded in the
// cycle it is offered and its result is in the output register from the accepting
// edge on; the output register holds its item under backpressure; a new item is
// taken whenever the output register is empty or being drained in the same cycle
// a read response that arrives while no walk is open produces no result
// reset (i_rst_n low, synchronous) clears the config registers, the walk
// level, the saved address and the output valid
module guest_page_table_walker_core
    import gptw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gptw_in_if.sink     i_req_ch,
    gptw_out_if.source  o_rsp_ch,
    gptw_cfg_if.sink    i_cfg_ch
);

    // config registers
    logic             r_paging_on;
    logic             r_pae_on;
    logic [AddrW-1:0] r_table_root;

    // walk state
    t_level           r_level;
    logic [AddrW-1:0] r_vaddr;

    // output register
    logic             r_out_valid;
    logic             r_out_is_result;
    logic [AddrW-1:0] r_out_req_addr;
    logic [AddrW-1:0] r_out_phys_addr;
    logic             r_out_fault;

    logic      n_out_valid;
    logic      in_accept;
    t_walk_out walk;

    // free to take an item when the result slot is empty or empties this cycle
    assign i_req_ch.ready = !r_out_valid || o_rsp_ch.ready;
    assign in_accept      = i_req_ch.valid && i_req_ch.ready;
    assign i_cfg_ch.ready = 1'b1;

    gptw_walk u_walk (
        .i_func       (i_req_ch.func),
        .i_virt_addr  (i_req_ch.virt_addr),
        .i_read_data  (i_req_ch.read_data),
        .i_level      (r_level),
        .i_vaddr      (r_vaddr),
        .i_paging_on  (r_paging_on),
        .i_pae_on     (r_pae_on),
        .i_table_root (r_table_root),
        .o_walk       (walk)
    );

    // slot stays full when stalled, refills on an emitting item
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp_ch.ready;
        if (in_accept && walk.emit) begin
            n_out_valid = 1'b1;
        end
    end

    // config writes, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging_on  <= 1'b0;
            r_pae_on     <= 1'b0;
            r_table_root <= '0;
        end else if (i_cfg_ch.valid && i_cfg_ch.ready) begin
            case (i_cfg_ch.index)
                CFG_PAGING_ON:  r_paging_on  <= i_cfg_ch.data[0];
                CFG_PAE_ON:     r_pae_on     <= i_cfg_ch.data[0];
                CFG_TABLE_ROOT: r_table_root <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    // walk state advances on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_IDLE;
            r_vaddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_accept) begin
                r_level <= walk.next_level;
                r_vaddr <= walk.next_vaddr;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept && walk.emit) begin
            r_out_is_result <= walk.is_result;
            r_out_req_addr  <= walk.req_addr;
            r_out_phys_addr <= walk.phys_addr;
            r_out_fault     <= walk.fault;
        end
    end

    assign o_rsp_ch.valid     = r_out_valid;
    assign o_rsp_ch.is_result = r_out_is_result;
    assign o_rsp_ch.req_addr  = r_out_req_addr;
    assign o_rsp_ch.phys_addr = r_out_phys_addr;
    assign o_rsp_ch.fault     = r_out_fault;

    // a read request never carries a translation or a fault
    a_req_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_is_result |-> !r_out_fault && r_out_phys_addr == '0)
        else $error("read request with result fields set");

    // a fault always reports the unmapped address
    a_fault_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fault |-> r_out_is_result && r_out_phys_addr == NOT_MAPPED)
        else $error("fault without unmapped address");

    // with paging off a translation finishes in one step
    a_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_req_ch.func == FUNC_TRANSLATE && !r_paging_on
        |=> r_out_valid && r_out_is_result && r_level == LVL_IDLE)
        else $error("paging-off translation did not finish");

    // a stray response leaves the walker idle and produces nothing new
    a_stray_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_req_ch.func == FUNC_READ_RESP && r_level == LVL_IDLE
        |=> r_level == LVL_IDLE && r_out_valid == $past(r_out_valid && !o_rsp_ch.ready))
        else $error("response while idle changed state");

    // a finished translation closes the walk
    a_close_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && walk.emit && walk.is_result |=> r_level == LVL_IDLE)
        else $error("walk still open after result");

endmodule

// ===== sv/gptw_walk.sv =====
`timescale 1ns / 1ps
// one step of the walk: decodes an item against the walk state
module gptw_walk
    import gptw_pkg::*;
(
    input  logic             i_func,
    input  logic [AddrW-1:0] i_virt_addr,
    input  logic [AddrW-1:0] i_read_data,
    input  t_level           i_level,
    input  logic [AddrW-1:0] i_vaddr,
    input  logic             i_paging_on,
    input  logic             i_pae_on,
    input  logic [AddrW-1:0] i_table_root,
    output t_walk_out        o_walk
);

    always_comb begin
        o_walk            = '0;
        o_walk.next_level = i_level;
        o_walk.next_vaddr = i_vaddr;

        if (i_func == FUNC_TRANSLATE) begin
            o_walk.emit       = 1'b1;
            o_walk.next_vaddr = i_virt_addr;
            if (!i_paging_on) begin
                o_walk.is_result  = 1'b1;
                o_walk.phys_addr  = i_virt_addr;
                o_walk.next_level = LVL_IDLE;
            end else begin
                o_walk.next_level = LVL_1;
                if (i_pae_on) begin
                    o_walk.req_addr = (i_table_root & PAE_ROOT_MASK)
                                    + {27'b0, i_virt_addr[31:30], 3'b0};
                end else begin
                    o_walk.req_addr = (i_table_root & ROOT_MASK)
                                    + {20'b0, i_virt_addr[31:22], 2'b0};
                end
            end
        end else if (i_level != LVL_IDLE) begin
            o_walk.emit = 1'b1;
            if (!i_read_data[BitPresent]) begin
                o_walk.is_result  = 1'b1;
                o_walk.phys_addr  = NOT_MAPPED;
                o_walk.fault      = 1'b1;
                o_walk.next_level = LVL_IDLE;
            end else if (i_pae_on) begin
                case (i_level)
                    LVL_1: begin
                        o_walk.req_addr   = (i_read_data & FRAME_4K_MASK)
                                          + {20'b0, i_vaddr[29:21], 3'b0};
                        o_walk.next_level = LVL_2;
                    end
                    LVL_2: begin
                        if (i_read_data[BitPs]) begin
                            o_walk.is_result  = 1'b1;
                            o_walk.phys_addr  = (i_read_data & FRAME_2M_MASK)
                                              + {11'b0, i_vaddr[20:0]};
                            o_walk.next_level = LVL_IDLE;
                        end else begin
                            o_walk.req_addr   = (i_read_data & FRAME_4K_MASK)
                                              + {20'b0, i_vaddr[20:12], 3'b0};
                            o_walk.next_level = LVL_3;
                        end
                    end
                    default: begin
                        o_walk.is_result  = 1'b1;
                        o_walk.phys_addr  = (i_read_data & FRAME_4K_MASK)
                                          + {20'b0, i_vaddr[11:0]};
                        o_walk.next_level = LVL_IDLE;
                    end
                endcase
            end else begin
                case (i_level)
                    LVL_1: begin
                        if (i_read_data[BitPs]) begin
                            o_walk.is_result  = 1'b1;
                            o_walk.phys_addr  = (i_read_data & FRAME_4M_MASK)
                                              + {10'b0, i_vaddr[21:0]};
                            o_walk.next_level = LVL_IDLE;
                        end else begin
                            o_walk.req_addr   = (i_read_data & FRAME_4K_MASK)
                                              + {20'b0, i_vaddr[21:12], 2'b0};
                            o_walk.next_level = LVL_2;
                        end
                    end
                    default: begin
                        o_walk.is_result  = 1'b1;
                        o_walk.phys_addr  = (i_read_data & FRAME_4K_MASK)
                                          + {20'b0, i_vaddr[11:0]};
                        o_walk.next_level = LVL_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
